>>> src/rbi_pkg.sv
// shared types and constants of the ray box intersection block
package rbi_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned HalfW  = 31;
  localparam int unsigned TolW   = 16;
  localparam int unsigned QuoW   = 50;  // magnitude of (bound - origin) << 16
  localparam int unsigned DivW   = 32;  // divisor magnitude width, up to 2^31
  localparam int unsigned RemW   = 32;  // partial remainder width
  localparam logic [TolW-1:0] TolReset = 16'd7;
  localparam logic signed [CoordW-1:0] MinusOne = -32'sd65536;
  localparam logic signed [CoordW-1:0] S32Max   = 32'sh7fffffff;
  localparam logic signed [CoordW-1:0] S32Min   = 32'sh80000000;

  typedef struct packed {
    logic signed [CoordW-1:0] ray_origin_x;
    logic signed [CoordW-1:0] ray_origin_y;
    logic signed [CoordW-1:0] ray_origin_z;
    logic signed [CoordW-1:0] ray_dir_x;
    logic signed [CoordW-1:0] ray_dir_y;
    logic signed [CoordW-1:0] ray_dir_z;
    logic signed [CoordW-1:0] box_center_x;
    logic signed [CoordW-1:0] box_center_y;
    logic signed [CoordW-1:0] box_center_z;
    logic [HalfW-1:0]         box_half_x;
    logic [HalfW-1:0]         box_half_y;
    logic [HalfW-1:0]         box_half_z;
  } ray_box_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
    logic [HalfW-1:0]         hit_distance;
  } hit_t;

  // per axis data carried alongside the divider
  typedef struct packed {
    logic signed [CoordW-1:0] org;
    logic signed [CoordW-1:0] dir;
    logic signed [33:0]       lo;
    logic signed [33:0]       hi;
  } axis_t;

  // divider stage control: sign of quotient and zero direction flag
  typedef struct packed {
    logic neg;
    logic zero;
  } div_ctl_t;

endpackage

>>> src/rbi_if.sv
// valid/ready channel interface carrying one payload per transaction
interface rbi_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/rbi_div_stage.sv
// one radix-2 restoring division step bank, registered, for a pipelined divider
module rbi_div_stage #(
  parameter int unsigned Steps = 5
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rbi_pkg::RemW-1:0]     rem_i,
  input  logic [rbi_pkg::QuoW-1:0]     num_i,
  input  logic [rbi_pkg::DivW-1:0]     den_i,
  output logic [rbi_pkg::RemW-1:0]     rem_o,
  output logic [rbi_pkg::QuoW-1:0]     num_o
);

  logic [rbi_pkg::RemW-1:0] rem_d;
  logic [rbi_pkg::QuoW-1:0] num_d;
  logic [rbi_pkg::RemW:0]   trial;
  logic [rbi_pkg::RemW-1:0] rem_q;
  logic [rbi_pkg::QuoW-1:0] num_q;

  // shift in numerator bits one at a time, quotient bits shift into num
  always_comb begin
    rem_d = rem_i;
    num_d = num_i;
    trial = '0;
    for (int s = 0; s < Steps; s++) begin
      trial = {rem_d, num_d[rbi_pkg::QuoW-1]} - {1'b0, den_i};
      num_d = {num_d[rbi_pkg::QuoW-2:0], 1'b0};
      if (!trial[rbi_pkg::RemW]) begin
        rem_d    = trial[rbi_pkg::RemW-1:0];
        num_d[0] = 1'b1;
      end else begin
        rem_d = {rem_d[rbi_pkg::RemW-2:0], num_i[rbi_pkg::QuoW-1-s]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign rem_o = rem_q;
  assign num_o = num_q;

endmodule

>>> src/ray_box_intersect.sv
// top level of the ray versus axis-aligned box test
//
//  channel   dir  payload     transaction when
//  in_if     in   ray_box_t   in_if.valid && in_if.ready
//  out_if    out  hit_t       out_if.valid && out_if.ready
//  cfg       in   16 bits     cfg_we_i high
//
// one transaction per cycle while the output is not stalled; registered stages in
// order: setup, ten divider stages of five quotient bits, select, multiply, check/output
// the divider stage bank sets the depth; every stage advances together
// reset clears the valid bits and sets the tolerance register tol_q to 7
// a stall at the output holds the whole pipeline, nothing is lost
module ray_box_intersect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  rbi_if.sink         in_if,
  rbi_if.source       out_if
);

  localparam int unsigned NDiv = 10;
  localparam int unsigned Lat  = NDiv + 4;

  logic [rbi_pkg::TolW-1:0] tol_q;
  logic [Lat-1:0]           vld_q;
  logic                     adv;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= rbi_pkg::TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // whole pipeline advances unless the output register is held
  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_if.valid};
    end
  end

  // stage 0: bounds, numerator magnitudes
  rbi_pkg::axis_t    ax_d [3];
  rbi_pkg::axis_t    ax_q [Lat-1][3];
  rbi_pkg::div_ctl_t ctl_d [3];
  rbi_pkg::div_ctl_t ctl_q [NDiv+1][3];
  logic [rbi_pkg::QuoW-1:0] num_d [3];
  logic [rbi_pkg::DivW-1:0] den_d [3];
  logic [rbi_pkg::DivW-1:0] den_q [NDiv+1][3];
  logic [rbi_pkg::QuoW-1:0] num_s [NDiv+1][3];
  logic [rbi_pkg::RemW-1:0] rem_s [NDiv+1][3];

  always_comb begin
    logic signed [rbi_pkg::CoordW-1:0] o, d, c;
    logic [rbi_pkg::HalfW-1:0]         h;
    logic signed [34:0]                diff;
    logic [33:0]                       mag;
    for (int a = 0; a < 3; a++) begin
      case (a)
        0: begin
          o = in_if.data.ray_origin_x; d = in_if.data.ray_dir_x;
          c = in_if.data.box_center_x; h = in_if.data.box_half_x;
        end
        1: begin
          o = in_if.data.ray_origin_y; d = in_if.data.ray_dir_y;
          c = in_if.data.box_center_y; h = in_if.data.box_half_y;
        end
        default: begin
          o = in_if.data.ray_origin_z; d = in_if.data.ray_dir_z;
          c = in_if.data.box_center_z; h = in_if.data.box_half_z;
        end
      endcase
      ax_d[a].org = o;
      ax_d[a].dir = d;
      ax_d[a].lo  = 34'(c) - 34'($signed({1'b0, h}));
      ax_d[a].hi  = 34'(c) + 34'($signed({1'b0, h}));
      diff = d[rbi_pkg::CoordW-1] ? 35'(ax_d[a].hi) - 35'(o) : 35'(ax_d[a].lo) - 35'(o);
      mag  = diff[34] ? 34'(-diff) : diff[33:0];
      num_d[a] = {mag, 16'd0};
      den_d[a] = d[rbi_pkg::CoordW-1] ? 32'(-33'(d)) : d[rbi_pkg::DivW-1:0];
      ctl_d[a].neg  = diff[34] ^ d[rbi_pkg::CoordW-1];
      ctl_d[a].zero = (d == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        ax_q[0][a]  <= ax_d[a];
        ctl_q[0][a] <= ctl_d[a];
        den_q[0][a] <= den_d[a];
        num_s[0][a] <= num_d[a];
        rem_s[0][a] <= '0;
      end
      for (int s = 1; s < Lat - 1; s++) ax_q[s] <= ax_q[s-1];
      for (int s = 1; s <= NDiv; s++) begin
        ctl_q[s] <= ctl_q[s-1];
        den_q[s] <= den_q[s-1];
      end
    end
  end

  // divider stages, five quotient bits each
  for (genvar s = 0; s < NDiv; s++) begin : g_div
    for (genvar a = 0; a < 3; a++) begin : g_ax
      rbi_div_stage #(.Steps(rbi_pkg::QuoW / NDiv)) u_stage (
        .clk_i (clk_i),
        .en_i  (adv),
        .rem_i (rem_s[s][a]),
        .num_i (num_s[s][a]),
        .den_i (den_q[s][a]),
        .rem_o (rem_s[s+1][a]),
        .num_o (num_s[s+1][a])
      );
    end
  end

  // select stage: signed saturated distances and their maximum
  logic signed [rbi_pkg::CoordW-1:0] t_d [3];
  logic signed [rbi_pkg::CoordW-1:0] best_d, best_q;
  always_comb begin
    logic [rbi_pkg::QuoW-1:0] qm;
    for (int a = 0; a < 3; a++) begin
      qm = num_s[NDiv][a];
      if (ctl_q[NDiv][a].zero) t_d[a] = rbi_pkg::MinusOne;
      else if (!ctl_q[NDiv][a].neg)
        t_d[a] = (qm > 50'h7fffffff) ? rbi_pkg::S32Max : 32'(qm);
      else
        t_d[a] = (qm > 50'h80000000) ? rbi_pkg::S32Min : 32'(-51'(qm));
    end
    best_d = t_d[0];
    if (t_d[1] > best_d) best_d = t_d[1];
    if (t_d[2] > best_d) best_d = t_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) best_q <= best_d;
  end

  // multiply stage: dir * best; the floor shift and origin add follow in the check stage
  logic signed [63:0] prod_q [3];
  logic signed [rbi_pkg::CoordW-1:0] bestm_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bestm_q <= best_q;
      for (int a = 0; a < 3; a++) prod_q[a] <= ax_q[NDiv+1][a].dir * best_q;
    end
  end

  // check stage into output register
  rbi_pkg::hit_t res_d, res_q;
  always_comb begin
    logic signed [48:0] pt [3];
    logic ok;
    ok = !bestm_q[rbi_pkg::CoordW-1];
    for (int a = 0; a < 3; a++) begin
      pt[a] = 49'(prod_q[a] >>> 16) + 49'(ax_q[Lat-2][a].org);
      if (pt[a] + 49'($signed({1'b0, tol_q})) < 49'(ax_q[Lat-2][a].lo)
          || pt[a] > 49'(ax_q[Lat-2][a].hi)) ok = 1'b0;
    end
    res_d = '0;
    if (ok) begin
      res_d.hit = 1'b1;
      res_d.hit_x = (pt[0] > 49'(rbi_pkg::S32Max)) ? rbi_pkg::S32Max :
                    (pt[0] < 49'(rbi_pkg::S32Min)) ? rbi_pkg::S32Min : 32'(pt[0]);
      res_d.hit_y = (pt[1] > 49'(rbi_pkg::S32Max)) ? rbi_pkg::S32Max :
                    (pt[1] < 49'(rbi_pkg::S32Min)) ? rbi_pkg::S32Min : 32'(pt[1]);
      res_d.hit_z = (pt[2] > 49'(rbi_pkg::S32Max)) ? rbi_pkg::S32Max :
                    (pt[2] < 49'(rbi_pkg::S32Min)) ? rbi_pkg::S32Min : 32'(pt[2]);
      res_d.hit_distance = bestm_q[rbi_pkg::HalfW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end
  assign out_if.data = res_q;

endmodule

>>> src/rbi_checker.sv
// port level checks of the ray box intersection block
module rbi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input rbi_pkg::hit_t out_data_i
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // input is refused only while the output is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input refused without output stall");

  // a miss carries zero hit_distance and zero hit_x
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.hit |->
      out_data_i.hit_distance == '0 && out_data_i.hit_x == '0)
    else $error("miss with nonzero fields");

endmodule

bind ray_box_intersect rbi_checker u_rbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);

>>> tb/tb_ray_box_intersect.sv
// self-checking testbench of the ray versus axis-aligned box test
module tb_ray_box_intersect;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit = 1_000_000;
  localparam int unsigned Latency  = 14;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  rbi_if #(.PayloadT(rbi_pkg::ray_box_t)) in_if ();
  rbi_if #(.PayloadT(rbi_pkg::hit_t))     out_if ();

  ray_box_intersect dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  rbi_pkg::hit_t expected_hits[$];
  logic [15:0]   tol_model;
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            idle_enable;
  int unsigned   hold_request;

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RunLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // expected hit for one ray and box under the given tolerance
  function automatic rbi_pkg::hit_t predict_hit(rbi_pkg::ray_box_t r, logic [15:0] tol);
    longint        org[3];
    longint        dir[3];
    longint        lo[3];
    longint        hi[3];
    longint        t_axis[3];
    longint        pt[3];
    longint        best;
    bit            ok;
    rbi_pkg::hit_t h;
    org[0] = longint'(r.ray_origin_x);
    org[1] = longint'(r.ray_origin_y);
    org[2] = longint'(r.ray_origin_z);
    dir[0] = longint'(r.ray_dir_x);
    dir[1] = longint'(r.ray_dir_y);
    dir[2] = longint'(r.ray_dir_z);
    lo[0] = longint'(r.box_center_x) - longint'({1'b0, r.box_half_x});
    lo[1] = longint'(r.box_center_y) - longint'({1'b0, r.box_half_y});
    lo[2] = longint'(r.box_center_z) - longint'({1'b0, r.box_half_z});
    hi[0] = longint'(r.box_center_x) + longint'({1'b0, r.box_half_x});
    hi[1] = longint'(r.box_center_y) + longint'({1'b0, r.box_half_y});
    hi[2] = longint'(r.box_center_z) + longint'({1'b0, r.box_half_z});
    // facing plane distance per axis, truncated quotient
    for (int i = 0; i < 3; i++) begin
      if (dir[i] > 0) begin
        t_axis[i] = sat32(((lo[i] - org[i]) * 65536) / dir[i]);
      end else if (dir[i] < 0) begin
        t_axis[i] = sat32(((hi[i] - org[i]) * 65536) / dir[i]);
      end else begin
        t_axis[i] = -65536;
      end
    end
    best = t_axis[0];
    if (t_axis[1] > best) best = t_axis[1];
    if (t_axis[2] > best) best = t_axis[2];
    ok = (best >= 0);
    // hit point inside the bounds, slack on the low side
    for (int i = 0; i < 3; i++) begin
      pt[i] = org[i] + ((dir[i] * best) >>> 16);
      if (ok && (pt[i] + longint'(tol) < lo[i] || pt[i] > hi[i])) ok = 0;
    end
    h = '0;
    if (ok) begin
      h.hit          = 1'b1;
      h.hit_x        = 32'(sat32(pt[0]));
      h.hit_y        = 32'(sat32(pt[1]));
      h.hit_z        = 32'(sat32(pt[2]));
      h.hit_distance = best[30:0];
    end
    return h;
  endfunction

  // prediction on every input transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_hits.push_back(predict_hit(in_if.data, tol_model));
    end
  end

  // compare every output transaction with the oldest expectation
  always @(posedge clk_i) begin
    rbi_pkg::hit_t exp_h;
    rbi_pkg::hit_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        error_count++;
      end else begin
        exp_h = expected_hits.pop_front();
        if (got.hit !== exp_h.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, exp_h.hit, got.hit);
          error_count++;
        end
        if (got.hit_x !== exp_h.hit_x) begin
          $display("%0t: hit_x exp %0d got %0d", $time, exp_h.hit_x, got.hit_x);
          error_count++;
        end
        if (got.hit_y !== exp_h.hit_y) begin
          $display("%0t: hit_y exp %0d got %0d", $time, exp_h.hit_y, got.hit_y);
          error_count++;
        end
        if (got.hit_z !== exp_h.hit_z) begin
          $display("%0t: hit_z exp %0d got %0d", $time, exp_h.hit_z, got.hit_z);
          error_count++;
        end
        if (got.hit_distance !== exp_h.hit_distance) begin
          $display("%0t: hit_distance exp %0d got %0d", $time,
                   exp_h.hit_distance, got.hit_distance);
          error_count++;
        end
      end
    end
  end

  // receiver: random stall bursts, and a long hold on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_request) @(negedge clk_i);
        hold_request = 0;
        out_if.ready <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // one input transaction; returns at the falling edge after acceptance
  task automatic send_ray(rbi_pkg::ray_box_t r);
    in_if.valid <= 1'b1;
    in_if.data  <= r;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    tol_model = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic rbi_pkg::ray_box_t make_ray(int ox, int oy, int oz,
                                                 int dx, int dy, int dz,
                                                 int cx, int cy, int cz,
                                                 int hx, int hy, int hz);
    rbi_pkg::ray_box_t r;
    r.ray_origin_x = ox; r.ray_origin_y = oy; r.ray_origin_z = oz;
    r.ray_dir_x = dx; r.ray_dir_y = dy; r.ray_dir_z = dz;
    r.box_center_x = cx; r.box_center_y = cy; r.box_center_z = cz;
    r.box_half_x = hx[30:0]; r.box_half_y = hy[30:0]; r.box_half_z = hz[30:0];
    return r;
  endfunction

  function automatic rbi_pkg::ray_box_t noise_ray();
    rbi_pkg::ray_box_t r;
    r.ray_origin_x = $urandom; r.ray_origin_y = $urandom; r.ray_origin_z = $urandom;
    r.ray_dir_x = $urandom; r.ray_dir_y = $urandom; r.ray_dir_z = $urandom;
    r.box_center_x = $urandom; r.box_center_y = $urandom; r.box_center_z = $urandom;
    r.box_half_x = 31'($urandom);
    r.box_half_y = 31'($urandom);
    r.box_half_z = 31'($urandom);
    return r;
  endfunction

  // ray aimed at a point near the box, so most reach the bound checks
  function automatic rbi_pkg::ray_box_t aimed_ray();
    int c[3];
    int h[3];
    int o[3];
    int d[3];
    int k;
    rbi_pkg::ray_box_t r;
    k = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      c[i] = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      h[i] = $urandom_range(0, 1 << 20);
      o[i] = c[i] + $signed($urandom_range(0, 1 << 27)) - (1 << 26);
      d[i] = (c[i] + $signed($urandom_range(0, 2 * h[i] + 2)) - h[i] - 1 - o[i]) >>> k;
      if ($urandom_range(0, 15) == 0) d[i] = 0;
    end
    r = make_ray(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2],
                 h[0], h[1], h[2]);
    return r;
  endfunction

  task automatic test_directed();
    // zero direction on every axis
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    // straight along +x, -x, +y and -z
    send_ray(make_ray(-10 << 16, 0, 0, 65536, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    send_ray(make_ray(10 << 16, 0, 0, -65536, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    send_ray(make_ray(0, -5 << 16, 0, 0, 65536, 0, 0, 0, 0, 65536, 65536, 65536));
    send_ray(make_ray(0, 0, 5 << 16, 0, 0, -65536, 0, 0, 0, 65536, 65536, 65536));
    // diagonal from a corner, distances tie on all axes
    send_ray(make_ray(-3 << 16, -3 << 16, -3 << 16, 65536, 65536, 65536,
                      0, 0, 0, 65536, 65536, 65536));
    // origin inside the box: all distances negative
    send_ray(make_ray(0, 0, 0, 65536, 65536, 65536, 0, 0, 0, 65536, 65536, 65536));
    // pointing away
    send_ray(make_ray(-10 << 16, 0, 0, -65536, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    // passing beside the box
    send_ray(make_ray(-10 << 16, 5 << 16, 0, 65536, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    // grazing just under the low edge, within and then just beyond default slack
    send_ray(make_ray(-10 << 16, -65536 - 5, 0, 65536, 0, 0, 0, 0, 0,
                      65536, 65536, 65536));
    send_ray(make_ray(-10 << 16, -65536 - 9, 0, 65536, 0, 0, 0, 0, 0,
                      65536, 65536, 65536));
    // tiny direction: quotient saturates
    send_ray(make_ray(32'h8000_0000, 0, 0, 1, 0, 0, 32'h7fff_ffff, 0, 0,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_ray(make_ray(32'h7fff_ffff, 0, 0, -1, 0, 0, 32'h8000_0000, 0, 0,
                      0, 32'h7fff_ffff, 32'h7fff_ffff));
    // extreme fields everywhere
    send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_ray(make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
    // hit point beyond the far side after saturation
    send_ray(make_ray(32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0,
                      32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 1, 1));
    wait_drained();
  endtask

  task automatic test_tolerance_settings();
    logic [15:0]       tol_set[4];
    rbi_pkg::ray_box_t edge_ray;
    tol_set = '{16'd0, 16'hffff, 16'h5a5a, 16'ha5a5};
    foreach (tol_set[s]) begin
      write_tolerance(tol_set[s]);
      for (int j = 0; j < 20; j++) begin
        edge_ray = make_ray(-10 << 16, -65536 - $signed($urandom_range(0, 70000)), 0,
                            65536, 0, 0, 0, 0, 0, 65536, 65536, 65536);
        send_ray(edge_ray);
        send_ray(aimed_ray());
        sender_gap();
      end
    end
    write_tolerance(rbi_pkg::TolReset);
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) < 7) send_ray(aimed_ray());
      else send_ray(noise_ray());
      sender_gap();
    end
  endtask

  task automatic test_backpressure();
    hold_request = 200;
    for (int j = 0; j < 60; j++) send_ray(aimed_ray());
  endtask

  task automatic test_drain_pause();
    test_random(40);
    wait_drained();
    test_random(40);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    tol_model    = rbi_pkg::TolReset;
    error_count  = 0;
    cycle_count  = 0;
    idle_enable  = 1'b1;
    hold_request = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_tolerance_settings();
    test_random(500);
    test_backpressure();
    test_drain_pause();
    write_tolerance(16'd1234);
    test_random(300);
    idle_enable = 1'b0;
    test_random(200);

    // end of run
    in_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (Latency + 6) @(negedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
